// File: src/rps_pkg.sv
// Shared types, codes and widths for the random pick set.
package rps_pkg;

	// Default number of element slots
	localparam int unsigned CapacityDef = 64;

	// Fixed field widths
	localparam int unsigned CmdW   = 2;
	localparam int unsigned ValueW = 32;
	localparam int unsigned DrawW  = 31;
	localparam int unsigned StatW  = 2;
	localparam int unsigned BitW   = $clog2(DrawW);

	// Input transfer layout, padded to whole bytes
	localparam int unsigned InW = ((CmdW + ValueW + DrawW + 7) / 8) * 8;

	// Commands
	typedef enum logic [CmdW-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_PICK   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [StatW-1:0] {
		ST_DONE  = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SCAN    = 8'b0000_0010,
		S_MOVE_RD = 8'b0000_0100,
		S_MOVE_WR = 8'b0000_1000,
		S_DIV     = 8'b0001_0000,
		S_PICK_RD = 8'b0010_0000,
		S_PICK_WT = 8'b0100_0000,
		S_FINISH  = 8'b1000_0000
	} state_t;

endpackage

// File: src/random_pick_set.sv
// Set of distinct values with insert, remove and random pick, one shared sequencer.
// Insert and remove: linear search, one stored entry per cycle;
// remove then moves the last element into the freed slot (S_MOVE_RD, S_MOVE_WR).
// Pick: restoring remainder unit for draw mod count, then a memory read (S_PICK_RD, S_PICK_WT).
// One item at a time; the result register lets the next item enter while a result waits.
// Reset (arst_n low) empties the set; the element memory itself is not cleared.
module random_pick_set
	import rps_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDef,
	localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned CW   = $clog2(CAPACITY + 1),
	localparam int unsigned OutW = ((StatW + ValueW + CW + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	// cmd [1:0], value [33:2], draw [64:34], zero padding above
	input  logic [InW-1:0]  s_axis_tdata,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// status [1:0], picked [33:2], size_now [33+CW:34], zero padding above
	output logic [OutW-1:0] m_axis_tdata,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready
);

	localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

	// Element memory
	logic [ValueW-1:0] mem [CAPACITY];
	logic [AW-1:0]     rd_addr;
	logic [ValueW-1:0] rd_data_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ValueW-1:0] wr_data;

	// Control and working registers
	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     cmp_idx_q;
	logic              rd_pend_q;
	logic [AW-1:0]     slot_q;
	cmd_t              cmd_q;
	logic [ValueW-1:0] value_q;
	logic [DrawW-1:0]  draw_q;
	logic [BitW-1:0]   bit_q;
	logic [CW-1:0]     rem_q;
	status_t           res_status_q;
	logic [ValueW-1:0] res_picked_q;

	// Output register
	logic              out_valid_q;
	logic [StatW-1:0]  out_status_q;
	logic [ValueW-1:0] out_picked_q;
	logic [CW-1:0]     out_size_q;

	logic              in_fire;
	logic              hit;
	logic              scan_end;
	logic [CW:0]       trial;
	logic              trial_ge;
	logic [CW-1:0]     count_dec;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign hit           = rd_pend_q && (rd_data_q == value_q);
	assign scan_end      = !rd_pend_q && (idx_q >= count_q);
	assign trial         = {rem_q, draw_q[bit_q]};
	assign trial_ge      = trial >= {1'b0, count_q};
	assign count_dec     = count_q - CW'(1);

	// Select memory read address
	always_comb begin
		unique case (state_q)
			S_MOVE_RD: rd_addr = count_dec[AW-1:0];
			S_PICK_RD: rd_addr = rem_q[AW-1:0];
			default:   rd_addr = idx_q[AW-1:0];
		endcase
	end

	// Write on insert append or remove move
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = value_q;
		if (state_q == S_SCAN && scan_end && cmd_q == CMD_INSERT && count_q != CapVal) begin
			wr_en = 1'b1;
		end else if (state_q == S_MOVE_WR) begin
			wr_en   = 1'b1;
			wr_addr = slot_q;
			wr_data = rd_data_q;
		end
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Latch the command on transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= cmd_t'(s_axis_tdata[CmdW-1:0]);
			value_q <= s_axis_tdata[CmdW +: ValueW];
			draw_q  <= s_axis_tdata[CmdW+ValueW +: DrawW];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			cmp_idx_q    <= '0;
			rd_pend_q    <= 1'b0;
			slot_q       <= '0;
			bit_q        <= '0;
			rem_q        <= '0;
			res_status_q <= ST_DONE;
			res_picked_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q        <= '0;
						rd_pend_q    <= 1'b0;
						rem_q        <= '0;
						bit_q        <= BitW'(DrawW - 1);
						res_status_q <= ST_DONE;
						res_picked_q <= '0;
						unique case (cmd_t'(s_axis_tdata[CmdW-1:0])) inside
							CMD_INSERT, CMD_REMOVE: state_q <= S_SCAN;
							CMD_PICK: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_FINISH;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_SCAN: begin
					// Issue the next read while comparing the previous one
					if (idx_q < count_q) begin
						rd_pend_q <= 1'b1;
						cmp_idx_q <= idx_q;
						idx_q     <= idx_q + CW'(1);
					end else begin
						rd_pend_q <= 1'b0;
					end
					if (hit) begin
						slot_q <= cmp_idx_q[AW-1:0];
						if (cmd_q == CMD_INSERT) begin
							res_status_q <= ST_MISS;
							state_q      <= S_FINISH;
						end else begin
							state_q <= S_MOVE_RD;
						end
					end else if (scan_end) begin
						if (cmd_q == CMD_REMOVE) begin
							res_status_q <= ST_MISS;
						end else if (count_q == CapVal) begin
							res_status_q <= ST_FULL;
						end else begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_FINISH;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					count_q <= count_dec;
					state_q <= S_FINISH;
				end
				S_DIV: begin
					// One restoring remainder step per cycle, draw bits high to low
					rem_q <= trial_ge ? CW'(trial - {1'b0, count_q}) : trial[CW-1:0];
					if (bit_q == '0) begin
						state_q <= S_PICK_RD;
					end else begin
						bit_q <= bit_q - BitW'(1);
					end
				end
				S_PICK_RD: state_q <= S_PICK_WT;
				S_PICK_WT: begin
					res_picked_q <= rd_data_q;
					state_q      <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load when free, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && (!out_valid_q || m_axis_tready)) begin
			out_status_q <= res_status_q;
			out_picked_q <= res_picked_q;
			out_size_q   <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OutW'({out_size_q, out_picked_q, out_status_q});

endmodule
